@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the step sequencer.
// Needs nothing but a clock and an active-low reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is held
`define CSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("step sequencer assertion failed");

// Next-cycle implication, masked while reset is held
`define CSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("step sequencer assertion failed");

`endif

@@ hdl/css_pkg.sv @@
// Package for the clocked step sequencer: register indexes, mode codes, field widths.
// No dependencies; used by the channel interfaces and the core.
package css_pkg;

    // Fixed field widths
    localparam int FRAC_W    = 16;
    localparam int TIDX_W    = 8;
    localparam int MODE_W    = 3;
    localparam int DIV_W     = 8;
    localparam int LEN_W     = 9;
    localparam int DLY_W     = 10;
    localparam int CFG_IDX_W = 3;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Direction modes; codes above MODE_PICK hold the step
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_UP   = 3'd0;
    localparam t_mode MODE_DOWN = 3'd1;
    localparam t_mode MODE_HOLD = 3'd2;
    localparam t_mode MODE_WALK = 3'd3;
    localparam t_mode MODE_PICK = 3'd4;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_MODE   = 3'd0;
    localparam t_cfg_idx REG_DIV    = 3'd1;
    localparam t_cfg_idx REG_LEN    = 3'd2;
    localparam t_cfg_idx REG_DELAY  = 3'd3;
    localparam t_cfg_idx REG_THRESH = 3'd4;

    // Reset values
    localparam logic [DIV_W-1:0] DIV_RST   = 8'd1;
    localparam logic [LEN_W-1:0] LEN_RST   = 9'd16;
    localparam logic [DLY_W-1:0] DLY_RST   = 10'd10;
    localparam logic [DIV_W-1:0] COUNT_MAX = 8'hFF;

endpackage

@@ hdl/css_if.sv @@
// Valid/ready channel interfaces of the step sequencer: input items, results, config writes.
// Depends on css_pkg for the fixed field widths.
interface css_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    import css_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           position_valid;
    logic [FRAC_W-1:0]              position;
    logic [FRAC_W-1:0]              random_value;
    logic [TIDX_W-1:0]              table_index;
    logic signed [SAMPLE_WIDTH-1:0] table_value;

    modport source (
        output valid, operation, sample_in, position_valid, position, random_value,
               table_index, table_value,
        input  ready
    );
    modport sink (
        input  valid, operation, sample_in, position_valid, position, random_value,
               table_index, table_value,
        output ready
    );
endinterface

interface css_out_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink (input valid, sample_out, output ready);
endinterface

interface css_cfg_if #(
    parameter int DATA_WIDTH = 16
) ();
    import css_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [DATA_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/css_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module css_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read word; hold it while the read is disabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/clocked_step_sequencer_core.sv @@
// Clocked step sequencer core: trigger counting, step selection, table memory, delay line.
// Depends on css_pkg, css_if.sv, css_ram and assert_macros.svh.
`include "assert_macros.svh"

// The core takes one beat per clock cycle while it is not stalled and not clearing
// the table. A sample beat (operation 0) counts a rising crossing of sample_in
// over the threshold; when the count reaches clock_divisions the step jumps by
// position or moves by direction mode, and the table entry at the step leaves
// through the sample delay as one result beat. A write beat (operation 1) loads
// one table entry and gives no result. A result passes the input register, the
// registered reads of the table memory and of the delay memory, one pipeline
// stage each, and the output register. After reset the core sweeps the table to
// zero, one entry a cycle, and accepts no beat until the sweep is done;
// configuration writes are taken at all times and belong to idle periods only.
// Input beats keep flowing while a result waits, until stage 3 holds a result.
module clocked_step_sequencer_core #(
    parameter int TABLE_DEPTH  = 256,
    parameter int DELAY_DEPTH  = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    css_cfg_if.sink   i_cfg,
    css_in_if.sink    i_in,
    css_out_if.source o_out
);
    import css_pkg::*;

    localparam int StepW = $clog2(TABLE_DEPTH);
    localparam int LenW  = $clog2(TABLE_DEPTH + 1);
    localparam int DlyAw = $clog2(DELAY_DEPTH);
    localparam int ProdW = FRAC_W + LenW;

    // Configuration registers
    logic [MODE_W-1:0]              r_cfg_mode;
    logic [DIV_W-1:0]               r_cfg_div;
    logic [LEN_W-1:0]               r_cfg_len;
    logic [DLY_W-1:0]               r_cfg_dly;
    logic signed [SAMPLE_WIDTH-1:0] r_cfg_thresh;

    // Table clearing sweep
    logic             r_clr_active;
    logic [StepW-1:0] r_clr_addr;

    // Sequencer state
    logic [StepW-1:0] r_step;
    logic [DIV_W-1:0] r_count;
    logic             r_level;
    logic [DlyAw-1:0] r_dly_ptr;
    logic             r_dly_full;

    // Stage 1: registered input beat
    logic                           r_s1_valid;
    logic                           r_s1_op;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_sample;
    logic                           r_s1_pos_vld;
    logic [FRAC_W-1:0]              r_s1_pos;
    logic [FRAC_W-1:0]              r_s1_rnd;
    logic [TIDX_W-1:0]              r_s1_tidx;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_tval;

    // Stage 2: table word at the RAM output; stage 3: delay word at the RAM output
    logic                           r_s2_valid;
    logic                           r_s3_valid;
    logic                           r_s3_bypass;
    logic                           r_s3_zero;
    logic signed [SAMPLE_WIDTH-1:0] r_s3_val;

    // Output register
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    // Combinational signals
    logic                     stall;
    logic                     in_fire;
    logic                     process;
    logic                     high;
    logic                     trig;
    logic [DIV_W-1:0]         cnt_inc;
    logic                     fire;
    logic [LenW-1:0]          len_eff;
    logic [FRAC_W-1:0]        frac;
    logic [ProdW-1:0]         prod;
    logic [StepW-1:0]         scaled;
    logic [LenW-1:0]          step_inc;
    logic [StepW-1:0]         step_up;
    logic [StepW-1:0]         step_down;
    logic [StepW-1:0]         n_step;
    logic                     tab_we;
    logic [StepW-1:0]         tab_waddr;
    logic [SAMPLE_WIDTH-1:0]  tab_wdata;
    logic [SAMPLE_WIDTH-1:0]  tab_rdata;
    logic [DlyAw-1:0]         dly_eff;
    logic [DlyAw-1:0]         dly_raddr;
    logic                     dly_written;
    logic                     dly_we;
    logic [SAMPLE_WIDTH-1:0]  dly_rdata;

    // Handshakes: stall only when stage 3 holds a result and the output is blocked
    assign stall       = r_s3_valid && r_out_valid && !o_out.ready;
    assign i_in.ready  = !stall && !r_clr_active;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode   <= MODE_UP;
            r_cfg_div    <= DIV_RST;
            r_cfg_len    <= LEN_RST;
            r_cfg_dly    <= DLY_RST;
            r_cfg_thresh <= SAMPLE_WIDTH'(1) <<< (SAMPLE_WIDTH - 2);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODE:   r_cfg_mode   <= i_cfg.data[MODE_W-1:0];
                REG_DIV:    r_cfg_div    <= i_cfg.data[DIV_W-1:0];
                REG_LEN:    r_cfg_len    <= i_cfg.data[LEN_W-1:0];
                REG_DELAY:  r_cfg_dly    <= i_cfg.data[DLY_W-1:0];
                REG_THRESH: r_cfg_thresh <= i_cfg.data[SAMPLE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Sweep the table to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == StepW'(TABLE_DEPTH - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Stage 1: register the accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!stall) begin
            r_s1_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op      <= i_in.operation;
            r_s1_sample  <= i_in.sample_in;
            r_s1_pos_vld <= i_in.position_valid;
            r_s1_pos     <= i_in.position;
            r_s1_rnd     <= i_in.random_value;
            r_s1_tidx    <= i_in.table_index;
            r_s1_tval    <= i_in.table_value;
        end
    end

    // Trigger detection, division and next step
    always_comb begin
        process = r_s1_valid && (r_s1_op == OP_SAMPLE);
        high    = r_s1_sample > r_cfg_thresh;
        trig    = high && !r_level;
        cnt_inc = (trig && (r_count != COUNT_MAX)) ? r_count + 1'b1 : r_count;
        fire    = cnt_inc >= r_cfg_div;

        // Clamp the sequence length to 1..TABLE_DEPTH
        if (r_cfg_len == '0) begin
            len_eff = LenW'(1);
        end else if (32'(r_cfg_len) > 32'(TABLE_DEPTH)) begin
            len_eff = LenW'(TABLE_DEPTH);
        end else begin
            len_eff = LenW'(r_cfg_len);
        end

        // Scale a 0.16 fraction by the length
        frac   = r_s1_pos_vld ? r_s1_pos : r_s1_rnd;
        prod   = ProdW'(frac) * ProdW'(len_eff);
        scaled = StepW'(prod[ProdW-1:FRAC_W]);

        step_inc  = LenW'(r_step) + LenW'(1);
        step_up   = (step_inc >= len_eff) ? '0 : StepW'(step_inc);
        step_down = ((r_step == '0) || (LenW'(r_step) > len_eff))
                    ? StepW'(len_eff - LenW'(1)) : r_step - 1'b1;

        n_step = r_step;
        if (process && fire) begin
            if (r_s1_pos_vld) begin
                n_step = scaled;
            end else begin
                case (r_cfg_mode)
                    MODE_UP:   n_step = step_up;
                    MODE_DOWN: n_step = step_down;
                    MODE_WALK: n_step = r_s1_rnd[FRAC_W-1] ? step_up : step_down;
                    MODE_PICK: n_step = scaled;
                    default:   n_step = r_step;
                endcase
            end
        end
    end

    // Advance the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_count <= '0;
            r_level <= 1'b0;
        end else if (!stall && process) begin
            r_step  <= n_step;
            r_count <= fire ? '0 : cnt_inc;
            r_level <= high;
        end
    end

    // Table port: clearing sweep, else a write beat with an index inside the table
    always_comb begin
        if (r_clr_active) begin
            tab_we    = 1'b1;
            tab_waddr = r_clr_addr;
            tab_wdata = '0;
        end else begin
            tab_we    = !stall && r_s1_valid && (r_s1_op == OP_WRITE)
                        && (32'(r_s1_tidx) < 32'(TABLE_DEPTH));
            tab_waddr = StepW'(r_s1_tidx);
            tab_wdata = r_s1_tval;
        end
    end

    css_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_re    (!stall),
        .i_raddr (n_step),
        .o_rdata (tab_rdata)
    );

    // Stage 2: table word is ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!stall) begin
            r_s2_valid <= process;
        end
    end

    // Delay tap address; entries not yet written since reset read as zero
    always_comb begin
        if (32'(r_cfg_dly) > 32'(DELAY_DEPTH - 1)) begin
            dly_eff = DlyAw'(DELAY_DEPTH - 1);
        end else begin
            dly_eff = DlyAw'(r_cfg_dly);
        end
        if (r_dly_ptr >= dly_eff) begin
            dly_raddr = r_dly_ptr - dly_eff;
        end else begin
            dly_raddr = DlyAw'(32'(r_dly_ptr) + 32'(DELAY_DEPTH) - 32'(dly_eff));
        end
        dly_written = r_dly_full || (dly_eff <= r_dly_ptr);
        dly_we      = r_s2_valid && !stall;
    end

    css_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DELAY_DEPTH)
    ) u_delay (
        .i_clk   (i_clk),
        .i_we    (dly_we),
        .i_waddr (r_dly_ptr),
        .i_wdata (tab_rdata),
        .i_re    (!stall),
        .i_raddr (dly_raddr),
        .o_rdata (dly_rdata)
    );

    // Advance the delay pointer once per sample beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_ptr  <= '0;
            r_dly_full <= 1'b0;
        end else if (dly_we) begin
            if (r_dly_ptr == DlyAw'(DELAY_DEPTH - 1)) begin
                r_dly_ptr  <= '0;
                r_dly_full <= 1'b1;
            end else begin
                r_dly_ptr <= r_dly_ptr + 1'b1;
            end
        end
    end

    // Stage 3: delay word is ready; keep the undelayed word for zero delay
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (!stall) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s3_bypass <= (dly_eff == '0);
            r_s3_zero   <= !dly_written;
            r_s3_val    <= tab_rdata;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!stall && r_s3_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall && r_s3_valid) begin
            if (r_s3_bypass) begin
                r_out <= r_s3_val;
            end else if (r_s3_zero) begin
                r_out <= '0;
            end else begin
                r_out <= dly_rdata;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out;

    // Checks
    `CSS_ASSERT_IMP(a_ptr_in_range, i_clk, i_rst_n, 1'b1, 32'(r_dly_ptr) < 32'(DELAY_DEPTH))
    `CSS_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, stall, r_s3_valid && r_out_valid)
    `CSS_ASSERT_NXT(a_result_lands, i_clk, i_rst_n, r_s3_valid && !stall, r_out_valid)
    `CSS_ASSERT_IMP(a_no_beat_in_sweep, i_clk, i_rst_n, r_clr_active, !r_s1_valid && !r_s2_valid)

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for clocked_step_sequencer_core: directed and random beats, checked
// against an in-bench model of triggers, steps, table and delay line.
// Depends on css_pkg, the channel interfaces in css_if.sv and the core itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import css_pkg::*;

    localparam int TBL_DEPTH = 256;
    localparam int DLY_DEPTH = 1024;
    localparam int SMP_W     = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES    = 13;
    localparam int PHASE_BEATS = 100;

    // Index past the register list; the core must ignore a write to it
    localparam t_cfg_idx REG_UNUSED = 3'd5;

    typedef struct {
        logic                    op;
        logic signed [SMP_W-1:0] smp;
        logic                    pos_v;
        logic [FRAC_W-1:0]       pos;
        logic [FRAC_W-1:0]       rnd;
        logic [TIDX_W-1:0]       idx;
        logic signed [SMP_W-1:0] val;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    css_in_if  #(.SAMPLE_WIDTH(SMP_W)) in_ch ();
    css_out_if #(.SAMPLE_WIDTH(SMP_W)) out_ch ();
    css_cfg_if #(.DATA_WIDTH(16))      cfg_ch ();

    clocked_step_sequencer_core #(
        .TABLE_DEPTH (TBL_DEPTH),
        .DELAY_DEPTH (DLY_DEPTH),
        .SAMPLE_WIDTH(SMP_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // Sequencer state as the block should hold it
    logic signed [SMP_W-1:0] step_table [TBL_DEPTH];
    logic signed [SMP_W-1:0] delay_mem  [DLY_DEPTH];
    int                      step_now;
    logic [DIV_W-1:0]        trig_cnt;
    logic                    trig_lvl;
    logic [DLY_W-1:0]        dly_ptr;

    t_mode                   mode_r;
    logic [DIV_W-1:0]        div_r;
    logic [LEN_W-1:0]        len_r;
    logic [DLY_W-1:0]        dly_r;
    logic signed [SMP_W-1:0] thr_r;

    logic signed [SMP_W-1:0] delayed_samples_q [$];
    int                      mismatch_count = 0;
    bit                      idle_off = 1'b0;
    int                      stall_left = 0;

    function automatic int seq_length();
        int l;
        l = len_r;
        if (l < 1) l = 1;
        if (l > TBL_DEPTH) l = TBL_DEPTH;
        return l;
    endfunction

    function automatic int step_up(int s, int l);
        return (s + 1 >= l) ? 0 : s + 1;
    endfunction

    function automatic int step_down(int s, int l);
        return (s == 0 || s > l) ? l - 1 : s - 1;
    endfunction

    // Clear state and registers to their reset values
    task automatic reset_sequencer_state();
        foreach (step_table[i]) step_table[i] = '0;
        foreach (delay_mem[i]) delay_mem[i] = '0;
        step_now = 0;
        trig_cnt = '0;
        trig_lvl = 1'b0;
        dly_ptr  = '0;
        mode_r   = MODE_UP;
        div_r    = DIV_RST;
        len_r    = LEN_RST;
        dly_r    = DLY_RST;
        thr_r    = 16'sd16384;
    endtask

    task automatic apply_register(t_cfg_idx idx, logic [15:0] data);
        case (idx)
            REG_MODE:   mode_r = data[MODE_W-1:0];
            REG_DIV:    div_r  = data[DIV_W-1:0];
            REG_LEN:    len_r  = data[LEN_W-1:0];
            REG_DELAY:  dly_r  = data[DLY_W-1:0];
            REG_THRESH: thr_r  = data;
            default: ;
        endcase
    endtask

    // Work out the delayed table value a sample beat produces and queue it; a write beat updates the table
    task automatic compute_sequencer_output(t_beat b);
        logic high;
        int   l;
        int   rd;
        if (b.op == OP_WRITE) begin
            step_table[b.idx] = b.val;
            return;
        end
        high = (b.smp > thr_r);
        if (high && !trig_lvl && trig_cnt < COUNT_MAX) trig_cnt = trig_cnt + 1'b1;
        trig_lvl = high;
        l = seq_length();
        if (trig_cnt >= div_r) begin
            trig_cnt = '0;
            if (b.pos_v) begin
                step_now = (int'(b.pos) * l) >> 16;
            end else begin
                case (mode_r)
                    MODE_UP:   step_now = step_up(step_now, l);
                    MODE_DOWN: step_now = step_down(step_now, l);
                    MODE_WALK: step_now = b.rnd[15] ? step_up(step_now, l)
                                                    : step_down(step_now, l);
                    MODE_PICK: step_now = (int'(b.rnd) * l) >> 16;
                    default: ;
                endcase
            end
        end
        delay_mem[dly_ptr] = step_table[step_now];
        rd = (int'(dly_ptr) + DLY_DEPTH - int'(dly_r)) % DLY_DEPTH;
        delayed_samples_q.push_back(delay_mem[rd]);
        dly_ptr = dly_ptr + 1'b1;
    endtask

    function automatic t_beat sample_beat(logic signed [SMP_W-1:0] smp, logic pos_v,
                                          logic [FRAC_W-1:0] pos, logic [FRAC_W-1:0] rnd);
        t_beat b;
        b.op    = OP_SAMPLE;
        b.smp   = smp;
        b.pos_v = pos_v;
        b.pos   = pos;
        b.rnd   = rnd;
        b.idx   = TIDX_W'($urandom);
        b.val   = SMP_W'($urandom);
        return b;
    endfunction

    function automatic t_beat write_beat(logic [TIDX_W-1:0] idx, logic signed [SMP_W-1:0] val);
        t_beat b;
        b = sample_beat(SMP_W'($urandom), 1'($urandom), FRAC_W'($urandom), FRAC_W'($urandom));
        b.op  = OP_WRITE;
        b.idx = idx;
        b.val = val;
        return b;
    endfunction

    // Mostly clean low/high pulses around the threshold, some raw noise and some table writes
    function automatic t_beat random_beat();
        t_beat b;
        int    r;
        int    t;
        int    s;
        r = $urandom_range(0, 99);
        t = thr_r;
        if (r < 12) begin
            if ($urandom_range(0, 1) == 0)
                return write_beat(TIDX_W'($urandom_range(0, seq_length() - 1)), SMP_W'($urandom));
            return write_beat(TIDX_W'($urandom), SMP_W'($urandom));
        end
        if (r < 56 && t < 32767)
            s = t + 1 + $urandom_range(0, 32766 - t);
        else if (r < 90)
            s = -32768 + $urandom_range(0, t + 32768);
        else
            s = $urandom_range(0, 65535) - 32768;
        b = sample_beat(SMP_W'(s), ($urandom_range(0, 99) < 15), FRAC_W'($urandom),
                        FRAC_W'($urandom));
        return b;
    endfunction

    // Register value with random bits above the register width
    function automatic logic [15:0] pad_word(int value, int width);
        logic [31:0] m;
        m = (32'd1 << width) - 1;
        return 16'(($urandom & ~m) | (value & m));
    endfunction

    task automatic write_register(t_cfg_idx idx, logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_register(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(int mode, int div, int len, int dly, int thr);
        write_register(REG_MODE,   pad_word(mode, MODE_W));
        write_register(REG_DIV,    pad_word(div, DIV_W));
        write_register(REG_LEN,    pad_word(len, LEN_W));
        write_register(REG_DELAY,  pad_word(dly, DLY_W));
        write_register(REG_THRESH, pad_word(thr, 16));
    endtask

    // Offer one beat, after an optional idle burst, and hold it until taken
    task automatic send_beat(t_beat b);
        int gap;
        if (!idle_off && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= b.op;
        in_ch.sample_in      <= b.smp;
        in_ch.position_valid <= b.pos_v;
        in_ch.position       <= b.pos;
        in_ch.random_value   <= b.rnd;
        in_ch.table_index    <= b.idx;
        in_ch.table_value    <= b.val;
        do @(posedge i_clk); while (!in_ch.ready);
        compute_sequencer_output(b);
    endtask

    // Drop valid, wait out every queued result and the pipeline behind it
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (delayed_samples_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reset registers: crossings at and around the default threshold
    task automatic test_reset_defaults();
        send_beat(write_beat(8'd1, 16'sh7FFF));
        send_beat(write_beat(8'd2, 16'sh8000));
        send_beat(sample_beat(16'sh8000, 1'b0, 16'h0000, 16'h0000));
        send_beat(sample_beat(16'sh7FFF, 1'b0, 16'hFFFF, 16'hFFFF));
        send_beat(sample_beat(16'sd16384, 1'b0, 16'h0000, 16'h8000));
        send_beat(sample_beat(16'sd16385, 1'b0, 16'h0000, 16'h7FFF));
        send_beat(sample_beat(16'sd0, 1'b0, 16'h5555, 16'hAAAA));
        settle_block();
    endtask

    // Field extremes with passthrough delay and full table length
    task automatic test_field_extremes();
        write_all(MODE_UP, 0, TBL_DEPTH, 0, -32768);
        send_beat(write_beat(8'd255, 16'sh7FFF));
        send_beat(write_beat(8'd0, 16'sh8000));
        send_beat(sample_beat(16'sh8000, 1'b1, 16'hFFFF, 16'h0000));
        send_beat(sample_beat(16'sh7FFF, 1'b1, 16'h0000, 16'hFFFF));
        send_beat(sample_beat(16'sd0, 1'b0, 16'hFFFF, 16'hFFFF));
        settle_block();
        write_register(REG_MODE, pad_word(MODE_PICK, MODE_W));
        write_register(REG_THRESH, 16'h7FFF);
        send_beat(sample_beat(16'sh7FFF, 1'b0, 16'h0000, 16'hFFFF));
        send_beat(sample_beat(16'sh8000, 1'b0, 16'hFFFF, 16'h0000));
        settle_block();
    endtask

    // Step left beyond a shortened length, then moved up and down from there
    task automatic test_short_length();
        write_all(MODE_HOLD, 0, TBL_DEPTH, 0, 0);
        send_beat(sample_beat(16'sd0, 1'b1, 16'hFFFF, 16'h0000));
        settle_block();
        write_register(REG_LEN, pad_word(4, LEN_W));
        write_register(REG_DIV, pad_word(255, DIV_W));
        send_beat(sample_beat(16'sd100, 1'b0, 16'h0000, 16'h0000));
        settle_block();
        write_register(REG_MODE, pad_word(MODE_UP, MODE_W));
        write_register(REG_DIV, pad_word(0, DIV_W));
        send_beat(sample_beat(16'sd0, 1'b0, 16'h0000, 16'h0000));
        settle_block();
        write_register(REG_LEN, pad_word(TBL_DEPTH, LEN_W));
        send_beat(sample_beat(16'sd0, 1'b1, 16'hFFFF, 16'h0000));
        settle_block();
        write_register(REG_MODE, pad_word(MODE_DOWN, MODE_W));
        write_register(REG_LEN, pad_word(4, LEN_W));
        send_beat(sample_beat(16'sd0, 1'b0, 16'h0000, 16'h0000));
        settle_block();
    endtask

    // Pick a register setting for one phase of random traffic
    task automatic configure_phase(int p);
        int mode;
        int div;
        int len;
        int dly;
        int thr;
        int r;
        mode = (p < 8) ? p : $urandom_range(0, 7);
        r = $urandom_range(0, 9);
        div = (r < 6) ? $urandom_range(0, 4) : (r < 8) ? $urandom_range(0, 255) :
              (r == 8) ? 255 : 0;
        r = $urandom_range(0, 9);
        len = (r < 6) ? $urandom_range(1, 32) : (r == 6) ? TBL_DEPTH : (r == 7) ? 0 :
              (r == 8) ? $urandom_range(257, 511) : 1;
        r = $urandom_range(0, 9);
        dly = (r < 7) ? $urandom_range(0, 16) : (r == 7) ? DLY_DEPTH - 1 :
              $urandom_range(0, DLY_DEPTH - 1);
        thr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) - 32768
                                          : $urandom_range(0, 8000) - 4000;
        // Pin the first phases to the register extremes
        case (p)
            0: begin div = 0; len = TBL_DEPTH; dly = DLY_DEPTH - 1; thr = 32767; end
            1: begin div = 255; len = 1; dly = 0; thr = -32768; end
            2: len = 0;
            3: len = 511;
            default: ;
        endcase
        write_all(mode, div, len, dly, thr);
        if (p == 2) write_register(REG_UNUSED, 16'($urandom));
    endtask

    // Phases of random beats; the last ones run without idling
    task automatic test_random_traffic();
        for (int p = 0; p < PHASES; p++) begin
            idle_off = (p >= PHASES - 2);
            configure_phase(p);
            for (int n = 0; n < PHASE_BEATS; n++) send_beat(random_beat());
            settle_block();
        end
    endtask

    // Hold result ready low in random bursts
    always @(posedge i_clk) begin : drive_result_ready
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest queued value
    always @(posedge i_clk) begin : check_results
        logic signed [SMP_W-1:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (delayed_samples_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: sample_out %0d", out_ch.sample_out);
            end else begin
                want = delayed_samples_q.pop_front();
                if (out_ch.sample_out !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("sample_out mismatch: expected %0d, got %0d",
                                 want, out_ch.sample_out);
                end
            end
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.operation      = OP_SAMPLE;
        in_ch.sample_in      = '0;
        in_ch.position_valid = 1'b0;
        in_ch.position       = '0;
        in_ch.random_value   = '0;
        in_ch.table_index    = '0;
        in_ch.table_value    = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_MODE;
        cfg_ch.data          = '0;
        out_ch.ready         = 1'b0;
        reset_sequencer_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_short_length();
        test_random_traffic();

        if (mismatch_count == 0 && delayed_samples_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Stop a hung run
    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
